@@ src/f16fr_pkg.sv @@
`default_nettype none
package f16fr_pkg;

    // result kinds
    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // line error codes
    localparam logic [7:0] ERR_OVERRUN = 8'd0;
    localparam logic [7:0] ERR_PARITY  = 8'd1;
    localparam logic [7:0] ERR_FRAMING = 8'd2;

    // frame done codes
    localparam logic [7:0] DONE_OK       = 8'd0;
    localparam logic [7:0] DONE_GARBAGE  = 8'd1;
    localparam logic [7:0] DONE_CHECKSUM = 8'd2;

    // header characters
    localparam logic [7:0] HDR_D = 8'h44;
    localparam logic [7:0] HDR_A = 8'h41;
    localparam logic [7:0] HDR_T = 8'h54;

    localparam logic [8:0] FLETCHER_MOD = 9'd255;

    // results one received byte can cause
    localparam int RES_MAX = 3;

    // result queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration
    localparam int         PADDR_W           = 3;
    localparam logic [0:0] REG_MAX_PAYLOAD   = 1'b0;
    localparam logic [15:0] MAX_PAYLOAD_RST  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] frame_length;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

@@ src/f16fr_parse.sv @@
`default_nettype none
module f16fr_parse (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    input  wire logic [7:0]                            rx_byte,
    input  wire logic                                  framing_fault,
    input  wire logic                                  overrun_error,
    input  wire logic                                  parity_fault,
    input  wire logic [15:0]                           max_payload,
    output f16fr_pkg::result_t [f16fr_pkg::RES_MAX-1:0] res,
    output logic [1:0]                                 res_cnt
);
    import f16fr_pkg::*;

    localparam logic [2:0] PH_D       = 3'd0;
    localparam logic [2:0] PH_A       = 3'd1;
    localparam logic [2:0] PH_T       = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_LEN_LO  = 3'd4;
    localparam logic [2:0] PH_CS_HI   = 3'd5;
    localparam logic [2:0] PH_CS_LO   = 3'd6;
    localparam logic [2:0] PH_PAYLOAD = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] ann_len_reg, ann_len_next;
    logic [15:0] exp_sum_reg, exp_sum_next;
    logic [15:0] taken_reg, taken_next;
    logic [7:0]  sum_lo_reg, sum_lo_next;
    logic [7:0]  sum_hi_reg, sum_hi_next;

    logic        err_v, data_v, done_v;
    logic [7:0]  err_code, done_code;
    logic [15:0] done_len;
    logic [15:0] limit;
    logic [7:0]  hdr_char;
    logic [8:0]  hi_sum, lo_sum;
    logic [7:0]  hi_mod, lo_mod;
    logic [15:0] taken_inc;
    logic [1:0]  n;

    // frame limit and header character for the current phase
    assign limit = (ann_len_reg < max_payload) ? ann_len_reg : max_payload;

    always_comb
    begin
        case (phase_reg)
            PH_D:    hdr_char = HDR_D;
            PH_A:    hdr_char = HDR_A;
            PH_T:    hdr_char = HDR_T;
            default: hdr_char = HDR_D;
        endcase
    end

    // fletcher sums mod 255, the running sums already reduced
    assign hi_sum    = {1'b0, sum_hi_reg} + {1'b0, rx_byte};
    assign hi_mod    = (hi_sum >= FLETCHER_MOD) ? 8'(hi_sum - FLETCHER_MOD) : hi_sum[7:0];
    assign lo_sum    = {1'b0, hi_mod} + {1'b0, sum_lo_reg};
    assign lo_mod    = (lo_sum >= FLETCHER_MOD) ? 8'(lo_sum - FLETCHER_MOD) : lo_sum[7:0];
    assign taken_inc = taken_reg + 16'd1;

    // line error reply, overrun first
    always_comb
    begin
        err_v    = overrun_error || parity_fault || framing_fault;
        if (overrun_error)
            err_code = ERR_OVERRUN;
        else if (parity_fault)
            err_code = ERR_PARITY;
        else
            err_code = ERR_FRAMING;
    end

    // parser state update
    always_comb
    begin
        phase_next   = phase_reg;
        ann_len_next = ann_len_reg;
        exp_sum_next = exp_sum_reg;
        taken_next   = taken_reg;
        sum_lo_next  = sum_lo_reg;
        sum_hi_next  = sum_hi_reg;
        data_v       = 1'b0;
        done_v       = 1'b0;
        done_code    = DONE_OK;
        done_len     = 16'd0;
        case (phase_reg)
            PH_D, PH_A, PH_T:
            begin
                if (rx_byte == hdr_char)
                begin
                    phase_next = phase_reg + 3'd1;
                end
                else
                begin
                    done_v      = 1'b1;
                    done_code   = DONE_GARBAGE;
                    phase_next  = PH_D;
                    taken_next  = 16'd0;
                    sum_lo_next = 8'd0;
                    sum_hi_next = 8'd0;
                end
            end
            PH_LEN_HI:
            begin
                ann_len_next = {rx_byte, 8'd0};
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                ann_len_next = {ann_len_reg[15:8], rx_byte};
                phase_next   = PH_CS_HI;
            end
            PH_CS_HI:
            begin
                exp_sum_next = {rx_byte, 8'd0};
                phase_next   = PH_CS_LO;
            end
            PH_CS_LO:
            begin
                exp_sum_next = {exp_sum_reg[15:8], rx_byte};
                taken_next   = 16'd0;
                sum_lo_next  = 8'd0;
                sum_hi_next  = 8'd0;
                if (limit == 16'd0)
                begin
                    // empty frame closes on the checksum byte
                    done_v     = 1'b1;
                    phase_next = PH_D;
                    if (exp_sum_next == 16'd0)
                    begin
                        done_code = DONE_OK;
                        done_len  = ann_len_reg;
                    end
                    else
                    begin
                        done_code = DONE_CHECKSUM;
                    end
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            default:
            begin
                data_v      = 1'b1;
                sum_hi_next = hi_mod;
                sum_lo_next = lo_mod;
                taken_next  = taken_inc;
                if (taken_inc >= limit)
                begin
                    done_v      = 1'b1;
                    phase_next  = PH_D;
                    taken_next  = 16'd0;
                    sum_lo_next = 8'd0;
                    sum_hi_next = 8'd0;
                    if ({hi_mod, lo_mod} == exp_sum_reg)
                    begin
                        done_code = DONE_OK;
                        done_len  = ann_len_reg;
                    end
                    else
                    begin
                        done_code = DONE_CHECKSUM;
                    end
                end
            end
        endcase
    end

    // pack the results in order and flag the final one
    always_comb
    begin
        res = '0;
        n   = 2'd0;
        if (err_v)
        begin
            res[n] = '{kind: KIND_ERROR, value: err_code, frame_length: 16'd0, last: 1'b0};
            n      = n + 2'd1;
        end
        if (data_v)
        begin
            res[n] = '{kind: KIND_DATA, value: rx_byte, frame_length: 16'd0, last: 1'b0};
            n      = n + 2'd1;
        end
        if (done_v)
        begin
            res[n] = '{kind: KIND_DONE, value: done_code, frame_length: done_len, last: 1'b0};
            n      = n + 2'd1;
        end
        if (n != 2'd0)
            res[n - 2'd1].last = 1'b1;
        res_cnt = item_valid ? n : 2'd0;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_D;
            ann_len_reg <= 16'd0;
            exp_sum_reg <= 16'd0;
            taken_reg   <= 16'd0;
            sum_lo_reg  <= 8'd0;
            sum_hi_reg  <= 8'd0;
        end
        else if (item_valid)
        begin
            phase_reg   <= phase_next;
            ann_len_reg <= ann_len_next;
            exp_sum_reg <= exp_sum_next;
            taken_reg   <= taken_next;
            sum_lo_reg  <= sum_lo_next;
            sum_hi_reg  <= sum_hi_next;
        end
    end

    // sums stay reduced mod 255
    a_sums_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_hi_reg != 8'hFF) && (sum_lo_reg != 8'hFF))
        else $error("fletcher sum left unreduced");

    // outside the payload phase no bytes are counted
    a_taken_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PAYLOAD) |-> (taken_reg == 16'd0))
        else $error("byte count not cleared outside payload");

    // a finished frame returns to the first header character
    a_done_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && done_v) |=> (phase_reg == PH_D))
        else $error("parser did not restart after frame end");

endmodule
`default_nettype wire

@@ src/f16fr_queue.sv @@
`default_nettype none
module f16fr_queue (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire f16fr_pkg::result_t [f16fr_pkg::RES_MAX-1:0] wr_data,
    input  wire logic [1:0]                             wr_cnt,
    output logic                                        room,
    output logic                                        rd_valid,
    input  wire logic                                   rd_stall,
    output f16fr_pkg::result_t                          rd_data
);
    import f16fr_pkg::*;

    result_t            mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;

    // space for the most results one item can bring
    assign room     = count_reg <= QCNT_W'(QDEPTH - RES_MAX);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid && !rd_stall;

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(wr_cnt);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
    assign count_next  = count_reg + QCNT_W'(wr_cnt) - QCNT_W'(pop);

    // result storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (2'(i) < wr_cnt)
                mem[wr_ptr_reg + QPTR_W'(i)] <= wr_data[i];
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_cnt != 2'd0) |-> (count_reg + QCNT_W'(wr_cnt) <= QCNT_W'(QDEPTH)))
        else $error("results written without room");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && wr_cnt == 2'd0) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("fill count wrong after read");

endmodule
`default_nettype wire

@@ src/fletcher16_frame_receiver.sv @@
`default_nettype none
// Fletcher-16 checked frame receiver. Each item is one received byte with its
// line error flags; frames are "DAT", a big-endian 16-bit length, a Fletcher-16
// checksum with the byte sum high, and the payload. A byte produces zero to three
// results (line error reply, payload byte, frame done), delivered one per cycle
// while out_stall is low, in that order with last set on the final one. An item
// waits in the input register and is parsed when the eight-entry result queue has
// three free slots, so with the output side taking a result every cycle the block
// sustains one byte per cycle for bytes that give at most one result, and the
// output rate of one result per cycle sets the pace otherwise. max_payload is
// written at address 0 and must only change while idle.
module fletcher16_frame_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // received bytes
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            framing_fault,
    input  wire logic                            overrun_error,
    input  wire logic                            parity_fault,
    // results
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           kind,
    output logic [7:0]                           value,
    output logic [15:0]                          frame_length,
    output logic                                 last,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [f16fr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import f16fr_pkg::*;

    logic        full_reg;
    logic [7:0]  byte_reg;
    logic        fe_reg, ovr_reg, par_reg;
    logic [15:0] max_payload_reg;
    logic        room, go, accept;
    logic [1:0]  res_cnt;
    result_t [RES_MAX-1:0] res;
    result_t     head;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {16'd0, max_payload_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RST;
        else if (psel && penable && pwrite && paddr[2] == REG_MAX_PAYLOAD)
            max_payload_reg <= pwdata[15:0];
    end

    // input register
    assign go       = full_reg && room;
    assign in_stall = full_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (accept)
            full_reg <= 1'b1;
        else if (go)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
            fe_reg   <= framing_fault;
            ovr_reg  <= overrun_error;
            par_reg  <= parity_fault;
        end
    end

    // frame parser
    f16fr_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (go),
        .rx_byte       (byte_reg),
        .framing_fault (fe_reg),
        .overrun_error (ovr_reg),
        .parity_fault  (par_reg),
        .max_payload   (max_payload_reg),
        .res           (res),
        .res_cnt       (res_cnt)
    );

    // result queue
    f16fr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (res),
        .wr_cnt   (res_cnt),
        .room     (room),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (head)
    );

    assign kind         = head.kind;
    assign value        = head.value;
    assign frame_length = head.frame_length;
    assign last         = head.last;

endmodule
`default_nettype wire

@@ dv/fletcher16_frame_receiver_tb.sv @@
`timescale 1ns / 100ps

module fletcher16_frame_receiver_tb;

    import f16fr_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 48;
    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = PADDR_W'(REG_MAX_PAYLOAD) << 2;

    typedef enum logic [2:0] {
        SEEK_D, SEEK_A, SEEK_T, LEN_HI, LEN_LO, SUM_HI, SUM_LO, BODY
    } frame_phase_t;

    // one received byte; n_typed below zero means the results come from the predictor
    typedef struct {
        logic [7:0]            data;
        logic                  ovr;
        logic                  par;
        logic                  fe;
        int                    n_typed;
        result_t [RES_MAX-1:0] typed;
    } rx_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'd0;
    logic        framing_fault = 1'b0;
    logic        overrun_error = 1'b0;
    logic        parity_fault = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] frame_length;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    fletcher16_frame_receiver u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .framing_fault (framing_fault),
        .overrun_error (overrun_error),
        .parity_fault  (parity_fault),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .value         (value),
        .frame_length  (frame_length),
        .last          (last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // parser state mirrored by the predictor
    logic [15:0]  max_payload_cfg = MAX_PAYLOAD_RST;
    frame_phase_t rx_phase = SEEK_D;
    logic [15:0]  ann_len = 16'd0;
    logic [15:0]  exp_sum = 16'd0;
    logic [15:0]  taken = 16'd0;
    int           sum_lo = 0;
    int           sum_hi = 0;

    result_t due_results[$];
    int      fail_count = 0;
    rx_row_t cur_row;
    int      burst_left = 0;
    int      hold_asks = 0;
    int      holds_done = 0;

    function automatic result_t mk_res(logic [1:0] k, logic [7:0] v, logic [15:0] len,
                                       logic lst);
        result_t r;
        r.kind = k;
        r.value = v;
        r.frame_length = len;
        r.last = lst;
        return r;
    endfunction

    function automatic logic [15:0] frame_cap();
        return (ann_len < max_payload_cfg) ? ann_len : max_payload_cfg;
    endfunction

    function automatic void restart_frame();
        rx_phase = SEEK_D;
        taken = 16'd0;
        sum_lo = 0;
        sum_hi = 0;
    endfunction

    // compare running sums with the announced checksum and go back to the header
    function automatic result_t close_frame();
        result_t r;
        if ({sum_hi[7:0], sum_lo[7:0]} == exp_sum)
            r = mk_res(KIND_DONE, DONE_OK, ann_len, 1'b0);
        else
            r = mk_res(KIND_DONE, DONE_CHECKSUM, 16'd0, 1'b0);
        restart_frame();
        return r;
    endfunction

    // results caused by one received byte, in delivery order
    function automatic int parse_rx(input logic [7:0] b, input logic ovr, input logic par,
                                    input logic fe, output result_t [RES_MAX-1:0] res);
        int n;
        n = 0;
        res = '0;
        if (ovr)
        begin
            res[n] = mk_res(KIND_ERROR, ERR_OVERRUN, 16'd0, 1'b0);
            n++;
        end
        else if (par)
        begin
            res[n] = mk_res(KIND_ERROR, ERR_PARITY, 16'd0, 1'b0);
            n++;
        end
        else if (fe)
        begin
            res[n] = mk_res(KIND_ERROR, ERR_FRAMING, 16'd0, 1'b0);
            n++;
        end
        case (rx_phase)
            SEEK_D, SEEK_A, SEEK_T:
            begin
                if ((rx_phase == SEEK_D && b == HDR_D) || (rx_phase == SEEK_A && b == HDR_A)
                    || (rx_phase == SEEK_T && b == HDR_T))
                    rx_phase = frame_phase_t'(rx_phase + 3'd1);
                else
                begin
                    res[n] = mk_res(KIND_DONE, DONE_GARBAGE, 16'd0, 1'b0);
                    n++;
                    restart_frame();
                end
            end
            LEN_HI:
            begin
                ann_len[15:8] = b;
                rx_phase = LEN_LO;
            end
            LEN_LO:
            begin
                ann_len[7:0] = b;
                rx_phase = SUM_HI;
            end
            SUM_HI:
            begin
                exp_sum[15:8] = b;
                rx_phase = SUM_LO;
            end
            SUM_LO:
            begin
                exp_sum[7:0] = b;
                taken = 16'd0;
                sum_lo = 0;
                sum_hi = 0;
                if (frame_cap() == 16'd0)
                begin
                    res[n] = close_frame();
                    n++;
                end
                else
                    rx_phase = BODY;
            end
            default:
            begin
                res[n] = mk_res(KIND_DATA, b, 16'd0, 1'b0);
                n++;
                sum_hi = (sum_hi + b) % 255;
                sum_lo = (sum_hi + sum_lo) % 255;
                taken = taken + 16'd1;
                if (taken >= frame_cap())
                begin
                    res[n] = close_frame();
                    n++;
                end
            end
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic cmp_field(string what, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // check delivered results, then predict from each accepted item
    always @(posedge clk)
    begin
        result_t [RES_MAX-1:0] pred;
        result_t want;
        int n;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got kind %0d value %0d",
                         $time, kind, value);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                cmp_field("kind", 16'(want.kind), 16'(kind));
                cmp_field("value", 16'(want.value), 16'(value));
                cmp_field("frame_length", want.frame_length, frame_length);
                cmp_field("last", 16'(want.last), 16'(last));
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            n = parse_rx(rx_byte, overrun_error, parity_fault, framing_fault, pred);
            if (cur_row.n_typed >= 0)
            begin
                n = cur_row.n_typed;
                pred = cur_row.typed;
            end
            for (int i = 0; i < n; i++)
                due_results.push_back(pred[i]);
        end
    end

    // receiver: random stall modes, plus long hold-offs on request
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        logic stall_nxt;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                stall_nxt = 1'b1;
            end
            else if (hold_asks > holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                stall_nxt = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                case (mode)
                    0: stall_nxt = 1'b0;
                    1: stall_nxt = 1'($urandom_range(0, 1));
                    default: stall_nxt = (mode_left % 4 == 0);
                endcase
            end
            out_stall <= stall_nxt;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        int idle_cycles;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic rx_row_t rx_in(logic [7:0] d, logic ovr, logic par, logic fe);
        rx_row_t r;
        r.data = d;
        r.ovr = ovr;
        r.par = par;
        r.fe = fe;
        r.n_typed = -1;
        r.typed = '0;
        return r;
    endfunction

    function automatic rx_row_t rx_in_exp(logic [7:0] d, logic ovr, logic par, logic fe,
                                          int n, result_t r0 = '0, result_t r1 = '0,
                                          result_t r2 = '0);
        rx_row_t r;
        r = rx_in(d, ovr, par, fe);
        r.n_typed = n;
        r.typed = {r2, r1, r0};
        return r;
    endfunction

    // sender: bursts of random length separated by random gaps
    task automatic send_item(rx_row_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_byte <= r.data;
        overrun_error <= r.ovr;
        parity_fault <= r.par;
        framing_fault <= r.fe;
        cur_row <= r;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // item with line error flags now and then
    task automatic offer_rx(logic [7:0] d);
        logic [2:0] flags;
        flags = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        send_item(rx_in(d, flags[2], flags[1], flags[0]));
    endtask

    task automatic send_frame(logic [15:0] len, logic good);
        logic [15:0] take;
        logic [7:0]  body[$];
        logic [7:0]  d;
        logic [15:0] cs;
        int s1;
        int s2;
        take = (len < max_payload_cfg) ? len : max_payload_cfg;
        s1 = 0;
        s2 = 0;
        for (int i = 0; i < take; i++)
        begin
            d = pick_data();
            body.push_back(d);
            s1 = (s1 + d) % 255;
            s2 = (s2 + s1) % 255;
        end
        cs = good ? {s1[7:0], s2[7:0]} : 16'($urandom);
        offer_rx(HDR_D);
        offer_rx(HDR_A);
        offer_rx(HDR_T);
        offer_rx(len[15:8]);
        offer_rx(len[7:0]);
        offer_rx(cs[15:8]);
        offer_rx(cs[7:0]);
        foreach (body[i])
            offer_rx(body[i]);
    endtask

    // sender stops until every result is out and the parser has settled
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic [15:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_PAYLOAD_ADDR;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        max_payload_cfg = v;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[15:0] !== v)
        begin
            $display("%0t: max_payload read back mismatch, expected %0d, got %0d",
                     $time, v, prdata[15:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // mix of well-formed frames, cut headers and noise
    task automatic run_phase(int goal, int max_len, logic wide_len);
        int sent;
        int sel;
        int k;
        logic [7:0] bad;
        logic [15:0] len;
        sent = 0;
        while (sent < goal)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                k = $urandom_range(1, 3);
                repeat (k) offer_rx(pick_data());
                sent += k;
            end
            else if (sel == 1)
            begin
                k = $urandom_range(1, 2);
                offer_rx(HDR_D);
                if (k == 2)
                    offer_rx(HDR_A);
                bad = pick_data();
                if (bad == ((k == 1) ? HDR_A : HDR_T))
                    bad = ~bad;
                offer_rx(bad);
                sent += k + 1;
            end
            else
            begin
                if (wide_len && $urandom_range(0, 3) == 0)
                    len = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
                else
                    len = 16'($urandom_range(0, max_len));
                send_frame(len, $urandom_range(0, 6) != 0);
                sent += 7 + ((len < max_payload_cfg) ? len : max_payload_cfg);
            end
        end
    endtask

    initial
    begin
        rx_row_t dir_rows[$];

        // directed items, results typed where obvious
        dir_rows.push_back(rx_in_exp(8'h00, 1'b0, 1'b0, 1'b0, 1,
                           mk_res(KIND_DONE, DONE_GARBAGE, 16'd0, 1'b1)));
        dir_rows.push_back(rx_in_exp(8'hFF, 1'b1, 1'b1, 1'b1, 2,
                           mk_res(KIND_ERROR, ERR_OVERRUN, 16'd0, 1'b0),
                           mk_res(KIND_DONE, DONE_GARBAGE, 16'd0, 1'b1)));
        dir_rows.push_back(rx_in_exp(HDR_D, 1'b0, 1'b1, 1'b1, 1,
                           mk_res(KIND_ERROR, ERR_PARITY, 16'd0, 1'b1)));
        dir_rows.push_back(rx_in_exp(HDR_A, 1'b0, 1'b0, 1'b1, 1,
                           mk_res(KIND_ERROR, ERR_FRAMING, 16'd0, 1'b1)));
        dir_rows.push_back(rx_in_exp(HDR_T, 1'b0, 1'b0, 1'b0, 0));
        // empty frame completes on the checksum low byte
        dir_rows.push_back(rx_in(8'h00, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h00, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h00, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in_exp(8'h00, 1'b0, 1'b0, 1'b0, 1,
                           mk_res(KIND_DONE, DONE_OK, 16'd0, 1'b1)));
        // two byte frame with a good checksum
        dir_rows.push_back(rx_in(HDR_D, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(HDR_A, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(HDR_T, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h00, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h02, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h01, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h01, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'hFF, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h01, 1'b0, 1'b0, 1'b0));
        // one byte frame, bad checksum, overrun on the last byte
        dir_rows.push_back(rx_in(HDR_D, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(HDR_A, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(HDR_T, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h00, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h01, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h12, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in(8'h34, 1'b0, 1'b0, 1'b0));
        dir_rows.push_back(rx_in_exp(8'hAB, 1'b1, 1'b0, 1'b0, 3,
                           mk_res(KIND_ERROR, ERR_OVERRUN, 16'd0, 1'b0),
                           mk_res(KIND_DATA, 8'hAB, 16'd0, 1'b0),
                           mk_res(KIND_DONE, DONE_CHECKSUM, 16'd0, 1'b1)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // reset limit: ordinary frames, then a long hold-off while the sender keeps going
        run_phase(10, 12, 1'b0);
        burst_left = 60;
        hold_asks++;
        send_frame(16'd24, 1'b1);

        // limit lowered below the bytes already taken in an open frame
        wait_drained();
        offer_rx(HDR_D);
        offer_rx(HDR_A);
        offer_rx(HDR_T);
        offer_rx(8'h00);
        offer_rx(8'h06);
        offer_rx(pick_data());
        offer_rx(pick_data());
        offer_rx(pick_data());
        offer_rx(pick_data());
        wait_drained();
        cfg_write(16'd1);
        offer_rx(pick_data());

        // every frame cut to at most one byte
        run_phase(10, 20, 1'b1);
        wait_drained();
        cfg_write(16'($urandom_range(2, 9)));

        // truncated frames, with a full drain halfway
        run_phase(6, 15, 1'b1);
        wait_drained();
        run_phase(6, 15, 1'b1);
        wait_drained();
        cfg_write(16'hFFFF);

        // back at the top limit
        run_phase(10, 12, 1'b0);

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
src/f16fr_pkg.sv
src/f16fr_parse.sv
src/f16fr_queue.sv
src/fletcher16_frame_receiver.sv
dv/fletcher16_frame_receiver_tb.sv
